FILE: rtl/core/crf_pkg.sv
// Shared types, request codes and helpers for the CPU register file.
package crf_pkg;

   typedef enum logic [2:0] {
      REQ_READ_REG  = 3'd0,
      REQ_WRITE_REG = 3'd1,
      REQ_READ_IE   = 3'd2,
      REQ_WRITE_IE  = 3'd3,
      REQ_SET_FLAGS = 3'd4,
      REQ_TEST_COND = 3'd5
   } req_code_type;

   typedef enum logic [3:0] {
      SEL_NONE = 4'd0,
      SEL_A    = 4'd1,
      SEL_F    = 4'd2,
      SEL_B    = 4'd3,
      SEL_C    = 4'd4,
      SEL_D    = 4'd5,
      SEL_E    = 4'd6,
      SEL_H    = 4'd7,
      SEL_L    = 4'd8,
      SEL_AF   = 4'd9,
      SEL_BC   = 4'd10,
      SEL_DE   = 4'd11,
      SEL_HL   = 4'd12,
      SEL_PC   = 4'd13,
      SEL_SP   = 4'd14
   } reg_sel_type;

   typedef enum logic [1:0] {
      FLAG_CLEAR = 2'd0,
      FLAG_SET   = 2'd1,
      FLAG_KEEP  = 2'd2
   } flag_ctl_type;

   typedef enum logic [2:0] {
      COND_ALWAYS = 3'd0,
      COND_C      = 3'd1,
      COND_NC     = 3'd2,
      COND_Z      = 3'd3,
      COND_NZ     = 3'd4
   } cond_code_type;

   typedef logic [7:0] byte_type;

   localparam int unsigned NUM_BYTE_REGS = 8;

   localparam logic [2:0] IDX_A = 3'd0;
   localparam logic [2:0] IDX_F = 3'd1;
   localparam logic [2:0] IDX_B = 3'd2;
   localparam logic [2:0] IDX_C = 3'd3;
   localparam logic [2:0] IDX_D = 3'd4;
   localparam logic [2:0] IDX_E = 3'd5;
   localparam logic [2:0] IDX_H = 3'd6;
   localparam logic [2:0] IDX_L = 3'd7;

   localparam int unsigned FLAG_Z_BIT = 7;
   localparam int unsigned FLAG_N_BIT = 6;
   localparam int unsigned FLAG_H_BIT = 5;
   localparam int unsigned FLAG_C_BIT = 4;

   // Codes other than clear and set leave the flag as it is.
   function automatic logic apply_flag(input logic [1:0] ctl, input logic cur);
      logic res;
      res = cur;
      case (ctl)
         FLAG_CLEAR: res = 1'b0;
         FLAG_SET:   res = 1'b1;
         default:    res = cur;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/core/cpu_register_file_with_flags.sv
// Top level of the CPU register file with flag update and condition test.
// An input transfer's result is registered and valid on rsp_ in the next cycle.
// One request per cycle unless req_stall; the result register frees as it is taken.
// Reset: synchronous, active high; clears byte registers, PC, SP, IE, rsp_valid.
// State updates at the input transfer edge, so the next request sees them.
module cpu_register_file_with_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_reg_sel,
   input  logic [15:0] req_write_value,
   input  logic [1:0]  req_zero_ctl,
   input  logic [1:0]  req_sub_ctl,
   input  logic [1:0]  req_half_ctl,
   input  logic [1:0]  req_carry_ctl,
   input  logic [2:0]  req_cond_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_cond_true
);

   crf_pkg::byte_type byte_regs_ff [crf_pkg::NUM_BYTE_REGS];
   crf_pkg::byte_type byte_regs_in [crf_pkg::NUM_BYTE_REGS];
   logic [15:0]       pc_ff, pc_in;
   logic [15:0]       sp_ff, sp_in;
   logic [7:0]        ie_ff, ie_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       read_data_ff, read_data_in;
   logic              cond_true_ff, cond_true_in;
   logic              accept;
   logic [15:0]       reg_read;
   logic              cond_eval;
   crf_pkg::byte_type flags;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign flags     = byte_regs_ff[crf_pkg::IDX_F];

   always_comb begin
      unique case (req_reg_sel)
         crf_pkg::SEL_A:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_A]};
         crf_pkg::SEL_F:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_F]};
         crf_pkg::SEL_B:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_B]};
         crf_pkg::SEL_C:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_C]};
         crf_pkg::SEL_D:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_D]};
         crf_pkg::SEL_E:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_E]};
         crf_pkg::SEL_H:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_H]};
         crf_pkg::SEL_L:  reg_read = {8'h00, byte_regs_ff[crf_pkg::IDX_L]};
         crf_pkg::SEL_AF: reg_read = {byte_regs_ff[crf_pkg::IDX_A],
                                      byte_regs_ff[crf_pkg::IDX_F]};
         crf_pkg::SEL_BC: reg_read = {byte_regs_ff[crf_pkg::IDX_B],
                                      byte_regs_ff[crf_pkg::IDX_C]};
         crf_pkg::SEL_DE: reg_read = {byte_regs_ff[crf_pkg::IDX_D],
                                      byte_regs_ff[crf_pkg::IDX_E]};
         crf_pkg::SEL_HL: reg_read = {byte_regs_ff[crf_pkg::IDX_H],
                                      byte_regs_ff[crf_pkg::IDX_L]};
         crf_pkg::SEL_PC: reg_read = pc_ff;
         crf_pkg::SEL_SP: reg_read = sp_ff;
         default:         reg_read = 16'h0000;
      endcase
   end

   always_comb begin
      unique case (req_cond_code)
         crf_pkg::COND_ALWAYS: cond_eval = 1'b1;
         crf_pkg::COND_C:      cond_eval = flags[crf_pkg::FLAG_C_BIT];
         crf_pkg::COND_NC:     cond_eval = ~flags[crf_pkg::FLAG_C_BIT];
         crf_pkg::COND_Z:      cond_eval = flags[crf_pkg::FLAG_Z_BIT];
         crf_pkg::COND_NZ:     cond_eval = ~flags[crf_pkg::FLAG_Z_BIT];
         default:              cond_eval = 1'b0;
      endcase
   end

   always_comb begin
      byte_regs_in = byte_regs_ff;
      pc_in        = pc_ff;
      sp_in        = sp_ff;
      ie_in        = ie_ff;
      read_data_in = read_data_ff;
      cond_true_in = cond_true_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         read_data_in = 16'h0000;
         cond_true_in = 1'b0;
         unique case (req_type)
            crf_pkg::REQ_READ_REG: read_data_in = reg_read;
            crf_pkg::REQ_WRITE_REG: begin
               unique case (req_reg_sel)
                  crf_pkg::SEL_A: byte_regs_in[crf_pkg::IDX_A] = req_write_value[7:0];
                  crf_pkg::SEL_F: byte_regs_in[crf_pkg::IDX_F] = req_write_value[7:0];
                  crf_pkg::SEL_B: byte_regs_in[crf_pkg::IDX_B] = req_write_value[7:0];
                  crf_pkg::SEL_C: byte_regs_in[crf_pkg::IDX_C] = req_write_value[7:0];
                  crf_pkg::SEL_D: byte_regs_in[crf_pkg::IDX_D] = req_write_value[7:0];
                  crf_pkg::SEL_E: byte_regs_in[crf_pkg::IDX_E] = req_write_value[7:0];
                  crf_pkg::SEL_H: byte_regs_in[crf_pkg::IDX_H] = req_write_value[7:0];
                  crf_pkg::SEL_L: byte_regs_in[crf_pkg::IDX_L] = req_write_value[7:0];
                  crf_pkg::SEL_AF: begin
                     byte_regs_in[crf_pkg::IDX_A] = req_write_value[15:8];
                     byte_regs_in[crf_pkg::IDX_F] = req_write_value[7:0];
                  end
                  crf_pkg::SEL_BC: begin
                     byte_regs_in[crf_pkg::IDX_B] = req_write_value[15:8];
                     byte_regs_in[crf_pkg::IDX_C] = req_write_value[7:0];
                  end
                  crf_pkg::SEL_DE: begin
                     byte_regs_in[crf_pkg::IDX_D] = req_write_value[15:8];
                     byte_regs_in[crf_pkg::IDX_E] = req_write_value[7:0];
                  end
                  crf_pkg::SEL_HL: begin
                     byte_regs_in[crf_pkg::IDX_H] = req_write_value[15:8];
                     byte_regs_in[crf_pkg::IDX_L] = req_write_value[7:0];
                  end
                  crf_pkg::SEL_PC: pc_in = req_write_value;
                  crf_pkg::SEL_SP: sp_in = req_write_value;
                  default: ;
               endcase
            end
            crf_pkg::REQ_READ_IE:  read_data_in = {8'h00, ie_ff};
            crf_pkg::REQ_WRITE_IE: ie_in = req_write_value[7:0];
            crf_pkg::REQ_SET_FLAGS: begin
               byte_regs_in[crf_pkg::IDX_F][crf_pkg::FLAG_Z_BIT] =
                  crf_pkg::apply_flag(req_zero_ctl, flags[crf_pkg::FLAG_Z_BIT]);
               byte_regs_in[crf_pkg::IDX_F][crf_pkg::FLAG_N_BIT] =
                  crf_pkg::apply_flag(req_sub_ctl, flags[crf_pkg::FLAG_N_BIT]);
               byte_regs_in[crf_pkg::IDX_F][crf_pkg::FLAG_H_BIT] =
                  crf_pkg::apply_flag(req_half_ctl, flags[crf_pkg::FLAG_H_BIT]);
               byte_regs_in[crf_pkg::IDX_F][crf_pkg::FLAG_C_BIT] =
                  crf_pkg::apply_flag(req_carry_ctl, flags[crf_pkg::FLAG_C_BIT]);
            end
            crf_pkg::REQ_TEST_COND: cond_true_in = cond_eval;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < crf_pkg::NUM_BYTE_REGS; i++) begin
            byte_regs_ff[i] <= 8'h00;
         end
         pc_ff        <= 16'h0000;
         sp_ff        <= 16'h0000;
         ie_ff        <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_regs_ff <= byte_regs_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         ie_ff        <= ie_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      cond_true_ff <= cond_true_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_cond_true = cond_true_ff;

endmodule
